[hdl/iol_pkg.sv]
`timescale 1ns / 1ps

package iol_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int VALUE_BITS_DEF = 16;
    localparam int GROUP_CELLS    = 8;

    localparam int REQ_W    = 3;
    localparam int POS_W    = 9;
    localparam int CODE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int FPOS_W   = 8;
    localparam int LEN_W    = 9;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 3'd0,
        REQ_HEAD   = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_DELETE = 3'd3,
        REQ_READ   = 3'd4,
        REQ_FIND   = 3'd5
    } req_t;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic ins;
        logic del;
        logic rd;
        logic fnd;
    } cell_ctl_t;

endpackage

[hdl/iol_cell.sv]
`timescale 1ns / 1ps

module iol_cell #(
    parameter int IDX        = 0,
    parameter int CMP_W      = 9,
    parameter int VALUE_BITS = iol_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  iol_pkg::cell_ctl_t    ctl,
    input  logic [CMP_W-1:0]      pos,
    input  logic [CMP_W-1:0]      cnt,
    input  logic [VALUE_BITS-1:0] val,
    input  logic [VALUE_BITS-1:0] left,
    input  logic [VALUE_BITS-1:0] right,
    output logic [VALUE_BITS-1:0] data,
    output logic                  hit
);

    localparam logic [CMP_W-1:0] ME = CMP_W'(IDX);

    logic [VALUE_BITS-1:0] data_reg;
    logic [VALUE_BITS-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (ME > pos)
                data_next = left;
            else if (ME == pos)
                data_next = val;
        end
        else if (ctl.del)
        begin
            if (ME >= pos)
                data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign hit  = (ME < cnt) && ((ctl.rd && (ME == pos)) || (ctl.fnd && (data_reg == val)));

endmodule

[hdl/iol_group.sv]
`timescale 1ns / 1ps

module iol_group #(
    parameter int VALUE_BITS = iol_pkg::VALUE_BITS_DEF
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 load,
    input  logic                                                 shift,
    input  logic [iol_pkg::GROUP_CELLS-1:0]                      hits,
    input  logic [iol_pkg::GROUP_CELLS-1:0][VALUE_BITS-1:0]      datas,
    input  logic                                                 nxt_any,
    input  logic [$clog2(iol_pkg::GROUP_CELLS)-1:0]              nxt_idx,
    input  logic [VALUE_BITS-1:0]                                nxt_data,
    output logic                                                 any,
    output logic [$clog2(iol_pkg::GROUP_CELLS)-1:0]              idx,
    output logic [VALUE_BITS-1:0]                                data
);

    localparam int LOC_W = $clog2(iol_pkg::GROUP_CELLS);

    logic                  any_reg;
    logic                  any_next;
    logic [LOC_W-1:0]      idx_reg;
    logic [LOC_W-1:0]      idx_next;
    logic [VALUE_BITS-1:0] data_reg;
    logic [VALUE_BITS-1:0] data_next;
    logic [LOC_W-1:0]      sel;

    // first hit within the group
    always_comb
    begin
        sel = '0;
        for (int j = iol_pkg::GROUP_CELLS - 1; j >= 0; j--)
        begin
            if (hits[j])
                sel = LOC_W'(j);
        end
    end

    always_comb
    begin
        any_next  = any_reg;
        idx_next  = idx_reg;
        data_next = data_reg;
        if (load)
        begin
            any_next  = |hits;
            idx_next  = sel;
            data_next = datas[sel];
        end
        else if (shift)
        begin
            any_next  = nxt_any;
            idx_next  = nxt_idx;
            data_next = nxt_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            any_reg <= 1'b0;
        else
            any_reg <= any_next;
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        data_reg <= data_next;
    end

    assign any  = any_reg;
    assign idx  = idx_reg;
    assign data = data_reg;

endmodule

[hdl/indexed_ordered_list.sv]
`timescale 1ns / 1ps

// Ordered list of up to DEPTH move codes held in a chain of cells. Append,
// insert at head, insert at position, delete and unused request codes give
// their result beat in the cycle after the request beat. Read and find
// capture the per-cell match of every cell at once into groups of eight
// cells, then step the group results down a shift chain one group per
// cycle until the first match or the last group. One request is in flight
// at a time; a new request beat is taken once the previous result is in
// the output register and that register is free or being drained.
module indexed_ordered_list #(
    parameter int DEPTH      = iol_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = iol_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [iol_pkg::REQ_W-1:0]     req_type,
    input  logic [iol_pkg::POS_W-1:0]     position,
    input  logic [iol_pkg::CODE_W-1:0]    move_code,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [iol_pkg::STATUS_W-1:0]  status,
    output logic [iol_pkg::CODE_W-1:0]    read_value,
    output logic                          found,
    output logic [iol_pkg::FPOS_W-1:0]    found_position,
    output logic [iol_pkg::LEN_W-1:0]     list_length
);

    localparam int GC     = iol_pkg::GROUP_CELLS;
    localparam int LOC_W  = $clog2(GC);
    localparam int NGRP   = (DEPTH + GC - 1) / GC;
    localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > iol_pkg::POS_W) ? CNT_W : iol_pkg::POS_W;
    localparam int FIX_W  = GRP_W + LOC_W;
    localparam int FP_W   = (FIX_W > iol_pkg::FPOS_W) ? FIX_W : iol_pkg::FPOS_W;
    localparam int LX_W   = (CNT_W > iol_pkg::LEN_W) ? CNT_W : iol_pkg::LEN_W;

    iol_pkg::state_t state_reg;
    iol_pkg::state_t state_next;

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [GRP_W-1:0]  scan_cnt_reg;
    logic [GRP_W-1:0]  scan_cnt_next;
    logic              is_find_reg;
    logic              is_find_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [iol_pkg::STATUS_W-1:0]  status_reg;
    logic [iol_pkg::STATUS_W-1:0]  status_next;
    logic [iol_pkg::CODE_W-1:0]    read_value_reg;
    logic [iol_pkg::CODE_W-1:0]    read_value_next;
    logic                          found_reg;
    logic                          found_next;
    logic [iol_pkg::FPOS_W-1:0]    fpos_reg;
    logic [iol_pkg::FPOS_W-1:0]    fpos_next;
    logic [iol_pkg::LEN_W-1:0]     len_reg;
    logic [iol_pkg::LEN_W-1:0]     len_next;

    logic                  accept;
    logic                  is_ins;
    logic                  ins_ok;
    logic                  del_ok;
    logic [CMP_W-1:0]      cnt_ext;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      ins_pos;
    logic [CMP_W-1:0]      cell_pos;
    logic [VALUE_BITS-1:0] val_in;
    logic [CNT_W-1:0]      cnt_after;
    logic [LX_W-1:0]       len_ext;
    logic [LX_W-1:0]       len_cur_ext;
    logic [FP_W-1:0]       fpos_ext;
    logic [iol_pkg::CODE_W-1:0] g0_data16;
    logic                  grp_load;
    logic                  grp_shift;
    logic                  scan_done;
    iol_pkg::cell_ctl_t    ctl;

    logic [NGRP*GC-1:0]                  hit_all;
    logic [NGRP*GC-1:0][VALUE_BITS-1:0]  data_all;
    logic [NGRP-1:0]                     g_any;
    logic [NGRP-1:0][LOC_W-1:0]          g_idx;
    logic [NGRP-1:0][VALUE_BITS-1:0]     g_data;

    assign accept  = in_valid && !in_stall;
    assign in_stall = (state_reg != iol_pkg::S_IDLE) || (out_valid_reg && out_stall);

    assign cnt_ext = CMP_W'(cnt_reg);
    assign pos_ext = CMP_W'(position);

    always_comb
    begin
        val_in = '0;
        for (int b = 0; b < VALUE_BITS && b < iol_pkg::CODE_W; b++)
            val_in[b] = move_code[b];
    end

    always_comb
    begin
        is_ins  = 1'b0;
        ins_pos = pos_ext;
        case (req_type)
            iol_pkg::REQ_APPEND:
            begin
                is_ins  = 1'b1;
                ins_pos = cnt_ext;
            end
            iol_pkg::REQ_HEAD:
            begin
                is_ins  = 1'b1;
                ins_pos = '0;
            end
            iol_pkg::REQ_INSERT:
            begin
                is_ins  = 1'b1;
            end
            default:
            begin
                is_ins  = 1'b0;
            end
        endcase
    end

    assign ins_ok   = (ins_pos <= cnt_ext) && (CNT_W'(DEPTH) > cnt_reg);
    assign del_ok   = pos_ext < cnt_ext;
    assign cell_pos = is_ins ? ins_pos : pos_ext;

    assign ctl.ins = accept && is_ins && ins_ok;
    assign ctl.del = accept && (req_type == iol_pkg::REQ_DELETE) && del_ok;
    assign ctl.rd  = req_type == iol_pkg::REQ_READ;
    assign ctl.fnd = req_type == iol_pkg::REQ_FIND;

    assign grp_load  = accept && (ctl.rd || ctl.fnd);
    assign scan_done = g_any[0] || (scan_cnt_reg == GRP_W'(NGRP - 1));
    assign grp_shift = (state_reg == iol_pkg::S_SCAN) && !scan_done;

    genvar gi;
    generate
        for (gi = 0; gi < NGRP * GC; gi++)
        begin : g_cells
            if (gi < DEPTH)
            begin : g_real
                iol_cell #(
                    .IDX        (gi),
                    .CMP_W      (CMP_W),
                    .VALUE_BITS (VALUE_BITS)
                ) u_cell (
                    .clk   (clk),
                    .ctl   (ctl),
                    .pos   (cell_pos),
                    .cnt   (cnt_ext),
                    .val   (val_in),
                    .left  (data_all[(gi > 0) ? gi - 1 : gi]),
                    .right (data_all[(gi < DEPTH - 1) ? gi + 1 : gi]),
                    .data  (data_all[gi]),
                    .hit   (hit_all[gi])
                );
            end
            else
            begin : g_pad
                assign data_all[gi] = '0;
                assign hit_all[gi]  = 1'b0;
            end
        end

        for (gi = 0; gi < NGRP; gi++)
        begin : g_groups
            logic                  n_any;
            logic [LOC_W-1:0]      n_idx;
            logic [VALUE_BITS-1:0] n_data;
            if (gi < NGRP - 1)
            begin : g_link
                assign n_any  = g_any[gi + 1];
                assign n_idx  = g_idx[gi + 1];
                assign n_data = g_data[gi + 1];
            end
            else
            begin : g_end
                assign n_any  = 1'b0;
                assign n_idx  = '0;
                assign n_data = '0;
            end
            iol_group #(
                .VALUE_BITS (VALUE_BITS)
            ) u_group (
                .clk      (clk),
                .rst_n    (rst_n),
                .load     (grp_load),
                .shift    (grp_shift),
                .hits     (hit_all[gi*GC +: GC]),
                .datas    (data_all[gi*GC +: GC]),
                .nxt_any  (n_any),
                .nxt_idx  (n_idx),
                .nxt_data (n_data),
                .any      (g_any[gi]),
                .idx      (g_idx[gi]),
                .data     (g_data[gi])
            );
        end
    endgenerate

    always_comb
    begin
        g0_data16 = '0;
        for (int b = 0; b < VALUE_BITS && b < iol_pkg::CODE_W; b++)
            g0_data16[b] = g_data[0][b];
    end

    assign fpos_ext    = FP_W'({scan_cnt_reg, g_idx[0]});
    assign len_ext     = LX_W'(cnt_next);
    assign len_cur_ext = LX_W'(cnt_reg);

    always_comb
    begin
        cnt_after = cnt_reg;
        if (ctl.ins)
            cnt_after = cnt_reg + 1'b1;
        else if (ctl.del)
            cnt_after = cnt_reg - 1'b1;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_after;
        scan_cnt_next   = scan_cnt_reg;
        is_find_next    = is_find_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        read_value_next = read_value_reg;
        found_next      = found_reg;
        fpos_next       = fpos_reg;
        len_next        = len_reg;
        case (state_reg)
            iol_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (ctl.rd || ctl.fnd)
                    begin
                        state_next    = iol_pkg::S_SCAN;
                        scan_cnt_next = '0;
                        is_find_next  = ctl.fnd;
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        read_value_next = '0;
                        found_next      = 1'b0;
                        fpos_next       = '0;
                        len_next        = len_ext[iol_pkg::LEN_W-1:0];
                        status_next     = iol_pkg::STAT_OK;
                        if (is_ins)
                        begin
                            if (ins_pos > cnt_ext)
                                status_next = iol_pkg::STAT_RANGE;
                            else if (!ins_ok)
                                status_next = iol_pkg::STAT_FULL;
                        end
                        else if ((req_type == iol_pkg::REQ_DELETE) && !del_ok)
                        begin
                            status_next = iol_pkg::STAT_RANGE;
                        end
                    end
                end
            end
            iol_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next     = iol_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                    len_next       = len_cur_ext[iol_pkg::LEN_W-1:0];
                    if (is_find_reg)
                    begin
                        status_next     = iol_pkg::STAT_OK;
                        read_value_next = '0;
                        found_next      = g_any[0];
                        fpos_next       = g_any[0] ? fpos_ext[iol_pkg::FPOS_W-1:0] : '0;
                    end
                    else
                    begin
                        status_next     = g_any[0] ? iol_pkg::STAT_OK : iol_pkg::STAT_RANGE;
                        read_value_next = g_any[0] ? g0_data16 : '0;
                        found_next      = 1'b0;
                        fpos_next       = '0;
                    end
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = iol_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iol_pkg::S_IDLE;
            cnt_reg       <= '0;
            scan_cnt_reg  <= '0;
            is_find_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            is_find_reg   <= is_find_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        read_value_reg <= read_value_next;
        found_reg      <= found_next;
        fpos_reg       <= fpos_next;
        len_reg        <= len_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign read_value     = read_value_reg;
    assign found          = found_reg;
    assign found_position = fpos_reg;
    assign list_length    = len_reg;

endmodule

[hdl/iol_checker.sv]
`timescale 1ns / 1ps

module iol_checker #(
    parameter int DEPTH = iol_pkg::DEPTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [iol_pkg::STATUS_W-1:0]  status,
    input logic [iol_pkg::CODE_W-1:0]    read_value,
    input logic                          found,
    input logic [iol_pkg::LEN_W-1:0]     list_length
);

    // length never beyond capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(list_length) <= DEPTH))
        else $error("list_length beyond DEPTH");

    // a match is only reported with ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (status == iol_pkg::STAT_OK))
        else $error("found with bad status");

    // read data only on a successful read beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (read_value != '0)) |-> ((status == iol_pkg::STAT_OK) && !found))
        else $error("read_value on a non-read beat");

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(list_length)))
        else $error("stalled result beat changed");

endmodule

bind indexed_ordered_list iol_checker #(
    .DEPTH (DEPTH)
) u_iol_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .read_value  (read_value),
    .found       (found),
    .list_length (list_length)
);
